// File: hw/rtl/sorted_list_insert_remove_search_macros.svh
// ----------------------------------------------------------------------------
// sorted list assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_REMOVE_SEARCH_MACROS_SVH
`define SORTED_LIST_INSERT_REMOVE_SEARCH_MACROS_SVH

// condition holds at every edge out of reset
`define SLI_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define SLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and constants of the sorted list block.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int CAPACITY = 16;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [COUNT_W-1:0]        t_count;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

    // update command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_cmd;

    // per-cell compare status
    typedef struct packed {
        logic lt;
        logic hit;
    } t_cell_stat;

endpackage

// File: hw/rtl/sli_cell.sv
// ----------------------------------------------------------------------------
// sli_cell
// One slot of the sorted row: compares its entry with the request value and
// takes the request value or a neighbour's entry on insert and remove.
// ----------------------------------------------------------------------------
module sli_cell
    import sli_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_cmd  i_cmd,
    input  t_value     i_value,
    input  logic       i_occupied,
    input  logic       i_left_lt,
    input  t_value     i_left_entry,
    input  t_value     i_right_entry,
    output t_cell_stat o_stat,
    output t_value     o_entry
);

    t_value r_entry;
    t_value n_entry;
    logic   w_lt;

    assign w_lt = i_occupied && (r_entry < i_value);

    // first slot not below the value is where an insert lands or a match sits
    assign o_stat.lt  = w_lt;
    assign o_stat.hit = i_occupied && !w_lt && i_left_lt && (r_entry == i_value);
    assign o_entry    = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins && !w_lt) begin
            n_entry = i_left_lt ? i_value : i_left_entry;
        end else if (i_cmd.rem && !w_lt) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: hw/rtl/sorted_list_insert_remove_search.sv
// result: the outcome of a request is registered when it is accepted and presented in the next cycle
// throughput: one request per cycle while the result register is free or being taken; the whole
// cell row compares and shifts at the edge that accepts the request, and one output register holds results
// reset: synchronous, active low; clears the entry count and the output valid,
// stored entries are left as they are and read only below the count
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_search
// Bounded sorted store of signed values with insert, remove and search.
// ----------------------------------------------------------------------------
`include "sorted_list_insert_remove_search_macros.svh"

module sorted_list_insert_remove_search
    import sli_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [1:0]   i_operation,
    input  t_value       i_value,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic         o_found,
    output logic         o_overflow,
    output t_count       o_entry_count
);

    t_count     r_count;
    t_count     n_count;
    logic       r_out_valid;
    logic       r_found;
    logic       r_overflow;
    logic       n_found;
    logic       n_overflow;
    logic       w_accept;
    logic       w_full;
    logic       w_any_hit;
    t_op        w_op;
    t_cell_cmd  w_cmd;

    t_value     w_entry [CAPACITY];
    t_cell_stat w_stat  [CAPACITY];
    logic [CAPACITY-1:0] w_hit;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_op       = t_op'(i_operation);
    assign w_full     = (r_count == COUNT_W'(CAPACITY));

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic   w_left_lt;
            t_value w_left_entry;
            t_value w_right_entry;

            if (g == 0) begin : g_head
                assign w_left_lt    = 1'b1;
                assign w_left_entry = i_value;
            end else begin : g_body
                assign w_left_lt    = w_stat[g-1].lt;
                assign w_left_entry = w_entry[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_right_entry = w_entry[g];
            end else begin : g_inner
                assign w_right_entry = w_entry[g+1];
            end

            sli_cell u_cell (
                .i_clk         (i_clk),
                .i_cmd         (w_cmd),
                .i_value       (i_value),
                .i_occupied    (COUNT_W'(g) < r_count),
                .i_left_lt     (w_left_lt),
                .i_left_entry  (w_left_entry),
                .i_right_entry (w_right_entry),
                .o_stat        (w_stat[g]),
                .o_entry       (w_entry[g])
            );

            assign w_hit[g] = w_stat[g].hit;
        end
    endgenerate

    assign w_any_hit = |w_hit;

    always_comb begin
        n_found    = 1'b0;
        n_overflow = 1'b0;
        n_count    = r_count;
        w_cmd      = '0;
        case (w_op)
            OP_INSERT: begin
                if (w_full) begin
                    n_overflow = 1'b1;
                end else begin
                    n_found   = 1'b1;
                    n_count   = r_count + 1'b1;
                    w_cmd.ins = w_accept;
                end
            end
            OP_REMOVE: begin
                n_found = w_any_hit;
                if (w_any_hit) begin
                    n_count   = r_count - 1'b1;
                    w_cmd.rem = w_accept;
                end
            end
            OP_SEARCH: begin
                n_found = w_any_hit;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_found    <= n_found;
            r_overflow <= n_overflow;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_overflow    = r_overflow;
    assign o_entry_count = r_count;

    `SLI_ASSERT_ALWAYS(a_count_bound, r_count <= COUNT_W'(CAPACITY), "count above capacity")
    `SLI_ASSERT_ALWAYS(a_flags_exclusive, !(o_out_valid && o_found && o_overflow), "found with overflow")
    `SLI_ASSERT_NEXT(a_full_drop, w_accept && (w_op == OP_INSERT) && w_full, o_out_valid && o_overflow && (r_count == $past(r_count)), "full insert not dropped")
    `SLI_ASSERT_NEXT(a_insert_grows, w_accept && (w_op == OP_INSERT) && !w_full, o_found && (r_count == $past(r_count) + 1'b1), "insert did not grow count")

endmodule

// File: bench/sorted_list_insert_remove_search_checker.sv
// ----------------------------------------------------------------------------
// sorted list checker
// Watches both channels of the sorted store, keeps its own copy of the
// ascending entries, predicts one outcome per accepted request and compares
// each result transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_search_checker
    import sli_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_operation,
    input  t_value     i_value,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_found,
    input  logic       i_overflow,
    input  t_count     i_entry_count,
    input  logic       i_drain_done,
    output int         o_fail_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic   found;
        logic   overflow;
        t_count count;
    } t_outcome;

    t_value   held_values [CAPACITY];
    int       held_count;
    t_outcome outcome_q [$];
    logic     leftovers_checked;

    initial begin
        o_fail_count      = 0;
        held_count        = 0;
        leftovers_checked = 1'b0;
    end

    // update the shadow store and return what the block should report
    function automatic t_outcome apply_request(logic [1:0] op, t_value v);
        t_outcome res;
        int       pos;
        int       k;
        res.found    = 1'b0;
        res.overflow = 1'b0;
        case (op)
            OP_INSERT: begin
                if (held_count >= CAPACITY) begin
                    res.overflow = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < held_count && held_values[pos] < v)
                        pos++;
                    for (k = held_count; k > pos; k--)
                        held_values[k] = held_values[k-1];
                    held_values[pos] = v;
                    held_count++;
                    res.found = 1'b1;
                end
            end
            OP_REMOVE: begin
                pos = -1;
                for (k = 0; k < held_count; k++)
                    if (pos < 0 && held_values[k] == v)
                        pos = k;
                if (pos >= 0) begin
                    for (k = pos; k + 1 < held_count; k++)
                        held_values[k] = held_values[k+1];
                    held_count--;
                    res.found = 1'b1;
                end
            end
            OP_SEARCH: begin
                for (k = 0; k < held_count; k++)
                    if (held_values[k] == v)
                        res.found = 1'b1;
            end
            default: ;
        endcase
        res.count = t_count'(held_count);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            held_count = 0;
            outcome_q.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                outcome_q.push_back(apply_request(i_operation, i_value));
            if (i_out_valid && i_out_ready) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: result transfer with nothing outstanding", $time);
                    o_fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (want != {i_found, i_overflow, i_entry_count})
                        o_fail_count++;
                    if (want.found != i_found)
                        $display("%0t: found expected %0b got %0b",
                                 $time, want.found, i_found);
                    if (want.overflow != i_overflow)
                        $display("%0t: overflow expected %0b got %0b",
                                 $time, want.overflow, i_overflow);
                    if (want.count != i_entry_count)
                        $display("%0t: entry_count expected %0d got %0d",
                                 $time, want.count, i_entry_count);
                end
            end
            if (i_drain_done && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (outcome_q.size() != 0) begin
                    $display("%0t: %0d results never arrived", $time, outcome_q.size());
                    o_fail_count += outcome_q.size();
                end
            end
        end
    end

endmodule

// File: bench/sorted_list_insert_remove_search_tb.sv
// ----------------------------------------------------------------------------
// sorted list testbench
// Directed corner requests then weighted random fill and drain traffic with
// three idling phases, a long output stall and drains between phases.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_search_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sli_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam t_value     VALUE_MIN  = 32'sh8000_0000;
    localparam t_value     VALUE_MAX  = 32'sh7fff_ffff;
    localparam int         PHASE_LEN  = 567;
    localparam int         LONG_STALL = 60;
    localparam int         CYCLE_CAP  = 200000;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic [1:0] i_operation   = OP_INSERT;
    t_value     i_value       = '0;
    logic       i_out_ready   = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_found;
    logic       o_overflow;
    t_count     o_entry_count;

    logic drain_done = 1'b0;
    int   fail_count;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   stall_asked  = 0;
    int   stall_served = 0;
    int   stall_left   = 0;
    int   n_sent = 0;
    int   n_taken = 0;
    int   cycle_count = 0;
    int   op_tally [4] = '{0, 0, 0, 0};

    sorted_list_insert_remove_search u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_overflow    (o_overflow),
        .o_entry_count (o_entry_count)
    );

    sorted_list_insert_remove_search_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_found       (o_found),
        .i_overflow    (o_overflow),
        .i_entry_count (o_entry_count),
        .i_drain_done  (drain_done),
        .o_fail_count  (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("sorted_list_insert_remove_search_tb: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                n_sent <= n_sent + 1;
            if (o_out_valid && i_out_ready)
                n_taken <= n_taken + 1;
        end
    end

    // receiver: random back-pressure, plus a long hold-off when one is asked for
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (stall_served != stall_asked) begin
            i_out_ready  <= 1'b0;
            stall_left   <= LONG_STALL;
            stall_served <= stall_served + 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_request(logic [1:0] op, t_value v);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_value     <= v;
        op_tally[op]++;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // hold the input quiet until every result is back
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (n_taken != n_sent)
            @(negedge i_clk);
    endtask

    // mostly a small pool so removes and searches hit, some extremes, some wide
    function automatic t_value pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return t_value'($urandom_range(15)) - 8;
        if (r < 70) begin
            case ($urandom_range(5))
                0: return VALUE_MIN;
                1: return VALUE_MAX;
                2: return VALUE_MIN + 1;
                3: return VALUE_MAX - 1;
                4: return '0;
                default: return -1;
            endcase
        end
        return t_value'($urandom());
    endfunction

    // alternate fill-heavy and drain-heavy stretches so the count sweeps 0..16
    function automatic logic [1:0] pick_op(int idx);
        int r;
        int ins_pct;
        int rem_pct;
        r = $urandom_range(99);
        ins_pct = ((idx / 80) % 2 == 0) ? 65 : 20;
        rem_pct = ((idx / 80) % 2 == 0) ? 15 : 55;
        if (r < 5)
            return OP_UNUSED;
        if (r < 5 + ins_pct)
            return OP_INSERT;
        if (r < 5 + ins_pct + rem_pct)
            return OP_REMOVE;
        return OP_SEARCH;
    endfunction

    task automatic run_phase(int tx_pct, int rx_pct, logic long_hold);
        @(negedge i_clk);
        tx_idle_pct <= tx_pct;
        rx_idle_pct <= rx_pct;
        if (long_hold)
            stall_asked <= stall_asked + 1;
        for (int n = 0; n < PHASE_LEN; n++)
            send_request(pick_op(n), pick_value());
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, duplicates, hits and misses, the unused code
        send_request(OP_INSERT, VALUE_MIN);
        send_request(OP_INSERT, VALUE_MAX);
        send_request(OP_INSERT, 0);
        send_request(OP_INSERT, -1);
        send_request(OP_INSERT, 0);
        send_request(OP_SEARCH, 0);
        send_request(OP_SEARCH, 5);
        send_request(OP_SEARCH, VALUE_MIN);
        send_request(OP_REMOVE, 0);
        send_request(OP_REMOVE, 7);
        send_request(OP_UNUSED, 0);
        send_request(OP_SEARCH, 0);
        for (int n = 0; n < 12; n++)
            send_request(OP_INSERT, t_value'(n * 1000 - 6000));
        // store now full, so this insert is dropped
        send_request(OP_INSERT, 42);
        send_request(OP_REMOVE, VALUE_MAX);
        send_request(OP_REMOVE, VALUE_MIN);
        wait_drained();

        run_phase(36, 87, 1'b0);
        run_phase(87, 36, 1'b0);
        run_phase(0, 0, 1'b1);

        repeat (5) @(negedge i_clk);
        drain_done <= 1'b1;
        @(posedge i_clk);
        @(negedge i_clk);

        $display("%0d requests, %0d results: %0d insert, %0d remove, %0d search, %0d unused",
                 n_sent, n_taken, op_tally[OP_INSERT], op_tally[OP_REMOVE],
                 op_tally[OP_SEARCH], op_tally[OP_UNUSED]);
        $display("three idling mixes, one long output hold-off, full drain between phases");
        if (fail_count == 0) begin
            $display("sorted_list_insert_remove_search_tb: clean");
        end else begin
            $display("sorted_list_insert_remove_search_tb: errors");
        end
        $finish;
    end

endmodule
